>>> hw/rtl/qi_pkg.sv
// Shared types, constants and helper functions for the quaternion interpolator.
package qi_pkg;

  localparam int COMP_WIDTH           = 16;
  localparam int FRAC_BITS            = 14;
  localparam int CW                   = 36;
  localparam int SQRT_STEPS           = 31;
  localparam int DIV_STEPS            = 30;
  localparam int DEFAULT_CORDIC_STEPS = 16;

  localparam logic signed [CW-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [CW-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [CW-1:0] GAIN_Q30    = 36'sd652032874;
  localparam logic [14:0]          ONE_K       = 15'd16384;

  typedef enum logic [0:0] {
    REG_MODE  = 1'b0,
    REG_LIMIT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic signed [15:0] first_w;
    logic signed [15:0] first_x;
    logic signed [15:0] first_y;
    logic signed [15:0] first_z;
    logic signed [15:0] second_w;
    logic signed [15:0] second_x;
    logic signed [15:0] second_y;
    logic signed [15:0] second_z;
    logic [14:0]        blend;
  } in_t;

  typedef struct packed {
    logic signed [15:0] out_w;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
    logic               fell_back;
  } out_t;

  typedef struct packed {
    in_t         item;
    logic [14:0] k;
    logic        pos;
    logic        cneg;
    logic [14:0] cabs;
    logic [31:0] ang;
    logic [30:0] sa;
    logic        fb;
    logic        ovf0;
    logic        ovf1;
  } side_t;

  function automatic logic signed [CW-1:0] atan_step(input int i);
    logic signed [CW-1:0] r;
    case (i)
      0:       r = 36'sd843314857;
      1:       r = 36'sd497837830;
      2:       r = 36'sd263043837;
      3:       r = 36'sd133525159;
      4:       r = 36'sd67021688;
      5:       r = 36'sd33543516;
      6:       r = 36'sd16775851;
      7:       r = 36'sd8388437;
      8:       r = 36'sd4194283;
      9:       r = 36'sd2097149;
      10:      r = 36'sd1048576;
      default: r = 36'sd1073741824 >>> i;
    endcase
    return r;
  endfunction

  // fold an angle in [0,pi] into [0,pi/2]
  function automatic logic signed [CW-1:0] fold(input logic [31:0] ang);
    logic signed [CW-1:0] t;
    t = $signed({4'b0, ang});
    if (t > HALF_PI_Q30) begin
      t = PI_Q30 - t;
    end
    return t;
  endfunction

endpackage

>>> hw/rtl/quaternion_interpolation.sv
// Quaternion linear / spherical interpolation pipeline, top level.
// Pipeline: 31 square-root cells, three CORDIC chains in series, 30 divider cells, plus 9 stages.
// Throughput: one item per cycle while in_stall_o is low; an output skid register holds one extra item.
// Reset clears all valid flags, selects spherical mode and a sine limit of 16.
module quaternion_interpolation
  import qi_pkg::*;
#(
  parameter int CORDIC_STEPS = DEFAULT_CORDIC_STEPS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_t        out_data_o,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [10:0] cfg_data_i
);

  localparam int N        = CORDIC_STEPS;
  localparam int S_PROD   = 1;
  localparam int S_DOT    = 2;
  localparam int S_M      = 3;
  localparam int S_SQ_END = S_M + SQRT_STEPS;
  localparam int AC_END   = S_SQ_END + N;
  localparam int S_ANG    = AC_END + 1;
  localparam int SN_END   = S_ANG + N;
  localparam int S_SA     = SN_END + 1;
  localparam int SP_END   = S_SA + N;
  localparam int S_DIVP   = SP_END + 1;
  localparam int DV_END   = S_DIVP + DIV_STEPS;
  localparam int S_W      = DV_END + 1;
  localparam int S_MUL    = DV_END + 2;
  localparam int LAT      = S_MUL + 1;

  logic        mode_q;
  logic [10:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b1;
      limit_q <= 11'd16;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MODE:  mode_q  <= cfg_data_i[0];
        REG_LIMIT: limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic en;
  logic skid_v_q, out_v_q;
  out_t skid_q, out_q;
  logic [LAT-1:0] v_q;
  side_t side_q [LAT];
  side_t side_n [LAT];

  assign en = !skid_v_q;

  // dot product
  logic signed [31:0] prod_q [4];
  logic signed [33:0] raw, raw_c, c_r;
  logic [14:0]        cabs;

  always_comb begin
    raw = 34'(prod_q[0]) + 34'(prod_q[1]) + 34'(prod_q[2]) + 34'(prod_q[3]);
    if (raw > 34'sd268435456) begin
      raw_c = 34'sd268435456;
    end else if (raw < -34'sd268435456) begin
      raw_c = -34'sd268435456;
    end else begin
      raw_c = raw;
    end
    c_r  = (raw_c + 34'sd8192) >>> FRAC_BITS;
    cabs = (c_r < 0) ? 15'(-c_r) : 15'(c_r);
  end

  // 1 - c^2 for the square root
  logic [29:0] csq;
  logic [28:0] m_q;
  assign csq = 30'(side_q[S_DOT].cabs) * 30'(side_q[S_DOT].cabs);

  // square root chain
  logic [61:0] sq_rad  [SQRT_STEPS+1];
  logic [35:0] sq_rem  [SQRT_STEPS+1];
  logic [30:0] sq_root [SQRT_STEPS+1];

  assign sq_rad[0]  = {1'b0, m_q, 32'b0};
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    qi_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .rad_i  (sq_rad[j]),
      .rem_i  (sq_rem[j]),
      .root_i (sq_root[j]),
      .rad_o  (sq_rad[j+1]),
      .rem_o  (sq_rem[j+1]),
      .root_o (sq_root[j+1])
    );
  end

  // acos by vectoring
  logic signed [CW-1:0] ac_x [N+1];
  logic signed [CW-1:0] ac_y [N+1];
  logic signed [CW-1:0] ac_z [N+1];

  assign ac_x[0] = $signed(CW'({side_q[S_SQ_END].cabs, 16'b0}));
  assign ac_y[0] = $signed(CW'(sq_root[SQRT_STEPS]));
  assign ac_z[0] = '0;

  // sine of the angle
  logic signed [CW-1:0] sn_x [N+1];
  logic signed [CW-1:0] sn_y [N+1];
  logic signed [CW-1:0] sn_z [N+1];

  assign sn_x[0] = GAIN_Q30;
  assign sn_y[0] = '0;
  assign sn_z[0] = fold(side_q[S_ANG].ang);

  // sines of the two partial angles
  logic [31:0] t0_q, t1_q;
  logic signed [CW-1:0] p0_x [N+1];
  logic signed [CW-1:0] p0_y [N+1];
  logic signed [CW-1:0] p0_z [N+1];
  logic signed [CW-1:0] p1_x [N+1];
  logic signed [CW-1:0] p1_y [N+1];
  logic signed [CW-1:0] p1_z [N+1];

  assign p0_x[0] = GAIN_Q30;
  assign p0_y[0] = '0;
  assign p0_z[0] = fold(t0_q);
  assign p1_x[0] = GAIN_Q30;
  assign p1_y[0] = '0;
  assign p1_z[0] = fold(t1_q);

  for (genvar j = 0; j < N; j++) begin : g_cordic
    qi_cordic_cell #(.STEP(j), .VECTOR(1'b1)) u_acos (
      .clk_i (clk_i), .en_i (en),
      .x_i (ac_x[j]), .y_i (ac_y[j]), .z_i (ac_z[j]),
      .x_o (ac_x[j+1]), .y_o (ac_y[j+1]), .z_o (ac_z[j+1])
    );
    qi_cordic_cell #(.STEP(j), .VECTOR(1'b0)) u_sin (
      .clk_i (clk_i), .en_i (en),
      .x_i (sn_x[j]), .y_i (sn_y[j]), .z_i (sn_z[j]),
      .x_o (sn_x[j+1]), .y_o (sn_y[j+1]), .z_o (sn_z[j+1])
    );
    qi_cordic_cell #(.STEP(j), .VECTOR(1'b0)) u_sin0 (
      .clk_i (clk_i), .en_i (en),
      .x_i (p0_x[j]), .y_i (p0_y[j]), .z_i (p0_z[j]),
      .x_o (p0_x[j+1]), .y_o (p0_y[j+1]), .z_o (p0_z[j+1])
    );
    qi_cordic_cell #(.STEP(j), .VECTOR(1'b0)) u_sin1 (
      .clk_i (clk_i), .en_i (en),
      .x_i (p1_x[j]), .y_i (p1_y[j]), .z_i (p1_z[j]),
      .x_o (p1_x[j+1]), .y_o (p1_y[j+1]), .z_o (p1_z[j+1])
    );
  end

  // angle fix-up
  logic signed [CW-1:0] zf, zc;
  always_comb begin
    zf = side_q[AC_END].cneg ? (PI_Q30 - ac_z[N]) : ac_z[N];
    if (zf < 0) begin
      zc = '0;
    end else if (zf > PI_Q30) begin
      zc = PI_Q30;
    end else begin
      zc = zf;
    end
  end

  // sine of angle, fallback test, partial angles
  logic [30:0] sa;
  logic [31:0] sa_r;
  logic        fb;
  logic [46:0] t0_p, t1_p;

  always_comb begin
    sa   = (sn_y[N] < 0) ? 31'd0 : sn_y[N][30:0];
    sa_r = (32'(sa) + 32'd32768) >> 16;
    fb   = mode_q && ((sa == 31'd0) || (sa_r < 32'(limit_q)));
    t0_p = 47'(side_q[SN_END].ang) * 47'(ONE_K - side_q[SN_END].k);
    t1_p = 47'(side_q[SN_END].ang) * 47'(side_q[SN_END].k);
  end

  // divider set-up
  logic [30:0] s0, s1;
  logic        ovf0, ovf1;
  logic [45:0] dv0_rem [DIV_STEPS+1];
  logic [29:0] dv0_q   [DIV_STEPS+1];
  logic [45:0] dv1_rem [DIV_STEPS+1];
  logic [29:0] dv1_q   [DIV_STEPS+1];
  logic [45:0] dv0_in_q, dv1_in_q;

  always_comb begin
    s0   = (p0_y[N] < 0) ? 31'd0 : p0_y[N][30:0];
    s1   = (p1_y[N] < 0) ? 31'd0 : p1_y[N][30:0];
    ovf0 = 61'({s0, 14'b0}) >= {side_q[SP_END].sa, 30'b0};
    ovf1 = 61'({s1, 14'b0}) >= {side_q[SP_END].sa, 30'b0};
  end

  assign dv0_rem[0] = dv0_in_q;
  assign dv1_rem[0] = dv1_in_q;
  assign dv0_q[0]   = '0;
  assign dv1_q[0]   = '0;

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    qi_div_cell #(.BIT(DIV_STEPS - 1 - j)) u_div0 (
      .clk_i (clk_i), .en_i (en), .sa_i (side_q[S_DIVP+j].sa),
      .rem_i (dv0_rem[j]), .q_i (dv0_q[j]),
      .rem_o (dv0_rem[j+1]), .q_o (dv0_q[j+1])
    );
    qi_div_cell #(.BIT(DIV_STEPS - 1 - j)) u_div1 (
      .clk_i (clk_i), .en_i (en), .sa_i (side_q[S_DIVP+j].sa),
      .rem_i (dv1_rem[j]), .q_i (dv1_q[j]),
      .rem_o (dv1_rem[j+1]), .q_o (dv1_q[j+1])
    );
  end

  // weights
  logic signed [31:0] kk, w0_d, w1_d, w0_q, w1_q;
  always_comb begin
    kk = $signed({17'b0, side_q[DV_END].k});
    if (mode_q && !side_q[DV_END].fb) begin
      w0_d = side_q[DV_END].ovf0 ? 32'sd1073741823 : $signed({2'b0, dv0_q[DIV_STEPS]});
      w1_d = side_q[DV_END].ovf1 ? 32'sd1073741823 : $signed({2'b0, dv1_q[DIV_STEPS]});
    end else begin
      w0_d = 32'sd16384 - kk;
      w1_d = side_q[DV_END].pos ? kk : -kk;
    end
  end

  // blend products
  logic signed [15:0] fa [4];
  logic signed [15:0] fq [4];
  logic signed [47:0] pa_q [4];
  logic signed [47:0] pb_q [4];
  logic signed [15:0] ra [4];
  logic signed [15:0] rb [4];

  always_comb begin
    fa[0] = side_q[S_W].item.first_w;
    fa[1] = side_q[S_W].item.first_x;
    fa[2] = side_q[S_W].item.first_y;
    fa[3] = side_q[S_W].item.first_z;
    fq[0] = side_q[S_W].item.second_w;
    fq[1] = side_q[S_W].item.second_x;
    fq[2] = side_q[S_W].item.second_y;
    fq[3] = side_q[S_W].item.second_z;
    ra[0] = side_q[0].item.first_w;
    ra[1] = side_q[0].item.first_x;
    ra[2] = side_q[0].item.first_y;
    ra[3] = side_q[0].item.first_z;
    rb[0] = side_q[0].item.second_w;
    rb[1] = side_q[0].item.second_x;
    rb[2] = side_q[0].item.second_y;
    rb[3] = side_q[0].item.second_z;
  end

  // final sum, round and saturate
  logic signed [48:0] sum [4];
  logic signed [48:0] rnd [4];
  logic signed [15:0] comp [4];
  out_t res;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      sum[j] = 49'(pa_q[j]) + 49'(pb_q[j]);
      rnd[j] = (sum[j] + 49'sd8192) >>> FRAC_BITS;
      if (rnd[j] > 49'sd32767) begin
        comp[j] = 16'sh7fff;
      end else if (rnd[j] < -49'sd32768) begin
        comp[j] = -16'sh8000;
      end else begin
        comp[j] = rnd[j][15:0];
      end
    end
    res.out_w     = comp[0];
    res.out_x     = comp[1];
    res.out_y     = comp[2];
    res.out_z     = comp[3];
    res.fell_back = side_q[LAT-1].fb;
  end

  // side band next values
  always_comb begin
    side_n[0]      = '0;
    side_n[0].item = in_data_i;
    side_n[0].k    = (in_data_i.blend > ONE_K) ? ONE_K : in_data_i.blend;
    for (int s = 1; s < LAT; s++) begin
      side_n[s] = side_q[s-1];
    end
    side_n[S_DOT].pos  = raw > 0;
    side_n[S_DOT].cneg = c_r < 0;
    side_n[S_DOT].cabs = cabs;
    side_n[S_ANG].ang  = zc[31:0];
    side_n[S_SA].sa    = sa;
    side_n[S_SA].fb    = fb;
    side_n[S_DIVP].ovf0 = ovf0;
    side_n[S_DIVP].ovf1 = ovf1;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int s = 0; s < LAT; s++) begin
        side_q[s] <= side_n[s];
      end
      for (int j = 0; j < 4; j++) begin
        prod_q[j] <= ra[j] * rb[j];
        pa_q[j]   <= fa[j] * w0_q;
        pb_q[j]   <= fq[j] * w1_q;
      end
      m_q      <= 29'(30'd268435456 - csq);
      t0_q     <= t0_p[45:14];
      t1_q     <= t1_p[45:14];
      dv0_in_q <= 46'({s0, 14'b0});
      dv1_in_q <= 46'({s1, 14'b0});
      w0_q     <= w0_d;
      w1_q     <= w1_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[LAT-2:0], in_valid_i};
    end
  end

  // output register and skid
  logic pop, inc;
  assign pop = out_v_q && !out_stall_i;
  assign inc = en && v_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (pop) begin
        skid_v_q <= 1'b0;
      end
    end else if (inc) begin
      if (!out_v_q || pop) begin
        out_v_q <= 1'b1;
      end else begin
        skid_v_q <= 1'b1;
      end
    end else if (pop) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (inc) begin
      if (!out_v_q || pop) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign in_stall_o  = skid_v_q;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

>>> hw/rtl/qi_cordic_cell.sv
// One CORDIC micro-rotation cell, vectoring or rotation mode.
module qi_cordic_cell
  import qi_pkg::*;
#(
  parameter int STEP   = 0,
  parameter bit VECTOR = 1'b0
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [CW-1:0] x_i,
  input  logic signed [CW-1:0] y_i,
  input  logic signed [CW-1:0] z_i,
  output logic signed [CW-1:0] x_o,
  output logic signed [CW-1:0] y_o,
  output logic signed [CW-1:0] z_o
);

  logic signed [CW-1:0] dx, dy;
  logic signed [CW-1:0] x_d, y_d, z_d, x_q, y_q, z_q;

  always_comb begin
    dx = y_i >>> STEP;
    dy = x_i >>> STEP;
    if (VECTOR) begin
      if (y_i >= 0) begin
        x_d = x_i + dx;
        y_d = y_i - dy;
        z_d = z_i + atan_step(STEP);
      end else begin
        x_d = x_i - dx;
        y_d = y_i + dy;
        z_d = z_i - atan_step(STEP);
      end
    end else begin
      if (z_i >= 0) begin
        x_d = x_i - dx;
        y_d = y_i + dy;
        z_d = z_i - atan_step(STEP);
      end else begin
        x_d = x_i + dx;
        y_d = y_i - dy;
        z_d = z_i + atan_step(STEP);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

>>> hw/rtl/qi_sqrt_cell.sv
// One digit cell of the integer square root chain.
module qi_sqrt_cell
  import qi_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [61:0] rad_i,
  input  logic [35:0] rem_i,
  input  logic [30:0] root_i,
  output logic [61:0] rad_o,
  output logic [35:0] rem_o,
  output logic [30:0] root_o
);

  logic [35:0] rem_n, trial;
  logic [61:0] rad_d, rad_q;
  logic [35:0] rem_d, rem_q;
  logic [30:0] root_d, root_q;

  always_comb begin
    rem_n = {rem_i[33:0], rad_i[61:60]};
    trial = {3'b0, root_i, 2'b01};
    rad_d = {rad_i[59:0], 2'b00};
    if (rem_n >= trial) begin
      rem_d  = rem_n - trial;
      root_d = {root_i[29:0], 1'b1};
    end else begin
      rem_d  = rem_n;
      root_d = {root_i[29:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= rad_d;
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign rad_o  = rad_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;

endmodule

>>> hw/rtl/qi_div_cell.sv
// One quotient bit cell of the restoring weight divider.
module qi_div_cell
  import qi_pkg::*;
#(
  parameter int BIT = 0
) (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [30:0] sa_i,
  input  logic [45:0] rem_i,
  input  logic [29:0] q_i,
  output logic [45:0] rem_o,
  output logic [29:0] q_o
);

  logic [61:0] dvs;
  logic [45:0] rem_d, rem_q;
  logic [29:0] q_d, q_q;

  always_comb begin
    dvs = 62'(sa_i) << BIT;
    if ({16'b0, rem_i} >= dvs) begin
      rem_d = rem_i - dvs[45:0];
      q_d   = q_i | (30'd1 << BIT);
    end else begin
      rem_d = rem_i;
      q_d   = q_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      q_q   <= q_d;
    end
  end

  assign rem_o = rem_q;
  assign q_o   = q_q;

endmodule

>>> tb/tb_quaternion_interpolation.sv
// Self-checking testbench for the quaternion interpolator: predictor, scoreboard and stimulus.
module tb_quaternion_interpolation;
  import qi_pkg::*;

  localparam int LATENCY = 3 * DEFAULT_CORDIC_STEPS + 70;
  localparam longint PI30 = 64'sd3373259426;
  localparam longint HPI30 = 64'sd1686629713;
  localparam longint GAIN30 = 64'sd652032874;
  localparam longint ONE = 64'sd16384;
  localparam longint WMAX = (64'sd1 <<< 30) - 1;

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_q(longint v, int s);
    if (s == 0) return v;
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint angle_step(int i);
    longint tab [11] = '{843314857, 497837830, 263043837, 133525159, 67021688,
                         33543516, 16775851, 8388437, 4194283, 2097149, 1048576};
    if (i < 11) return tab[i];
    return (64'sd1 <<< 30) >>> i;
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  function automatic longint arc_cos(longint c30);
    longint ac, x, y, z, dx, dy;
    longint unsigned one30;
    ac = c30 < 0 ? -c30 : c30;
    one30 = 64'd1 << 30;
    x = ac;
    y = int_sqrt(one30 * one30 - longint'(ac) * ac);
    z = 0;
    for (int i = 0; i < DEFAULT_CORDIC_STEPS; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += angle_step(i);
      end else begin
        x -= dx; y += dy; z -= angle_step(i);
      end
    end
    if (c30 < 0) z = PI30 - z;
    if (z < 0) z = 0;
    if (z > PI30) z = PI30;
    return z;
  endfunction

  function automatic longint sine(longint t);
    longint x, y, dx, dy;
    x = GAIN30;
    y = 0;
    if (t > HPI30) t = PI30 - t;
    for (int i = 0; i < DEFAULT_CORDIC_STEPS; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      if (t >= 0) begin
        x -= dx; y += dy; t -= angle_step(i);
      end else begin
        x += dx; y -= dy; t += angle_step(i);
      end
    end
    return y < 0 ? 0 : y;
  endfunction

  function automatic longint sine_weight(longint s, longint sa);
    longint unsigned w;
    w = (longint'(s) << 14) / longint'(sa);
    return w > WMAX ? WMAX : longint'(w);
  endfunction

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic out_t interpolate(in_t q, logic mode, logic [10:0] limit);
    longint a [4], b [4], raw, c, k, w0, w1, ang, sa, lim;
    out_t r;
    a = '{q.first_w, q.first_x, q.first_y, q.first_z};
    b = '{q.second_w, q.second_x, q.second_y, q.second_z};
    raw = 0;
    for (int j = 0; j < 4; j++) raw += a[j] * b[j];
    k = q.blend;
    if (k > ONE) k = ONE;
    w0 = ONE - k;
    w1 = raw > 0 ? k : -k;
    r.fell_back = 1'b0;
    if (mode) begin
      lim = ONE <<< 14;
      if (raw > lim) raw = lim;
      if (raw < -lim) raw = -lim;
      c = round_q(raw, 14);
      if (c > ONE) c = ONE;
      if (c < -ONE) c = -ONE;
      ang = arc_cos(c * 65536);
      sa = sine(ang);
      if (sa == 0 || round_q(sa, 16) < longint'(limit)) begin
        r.fell_back = 1'b1;
      end else begin
        w0 = sine_weight(sine((ang * (ONE - k)) >>> 14), sa);
        w1 = sine_weight(sine((ang * k) >>> 14), sa);
      end
    end
    r.out_w = clip16(round_q(a[0] * w0 + b[0] * w1, 14));
    r.out_x = clip16(round_q(a[1] * w0 + b[1] * w1, 14));
    r.out_y = clip16(round_q(a[2] * w0 + b[2] * w1, 14));
    r.out_z = clip16(round_q(a[3] * w0 + b[3] * w1, 14));
    return r;
  endfunction

  class interp_scoreboard;
    out_t pending [$];
    int errors;
    logic mode;
    logic [10:0] limit;

    function void note_item(in_t q);
      pending.push_back(interpolate(q, mode, limit));
    endfunction

    function void check_result(out_t got);
      out_t e;
      if (pending.size() == 0) begin
        $error("unexpected result item %h", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.out_w !== e.out_w) begin
        $error("out_w expected %0d actual %0d", e.out_w, got.out_w); errors++;
      end
      if (got.out_x !== e.out_x) begin
        $error("out_x expected %0d actual %0d", e.out_x, got.out_x); errors++;
      end
      if (got.out_y !== e.out_y) begin
        $error("out_y expected %0d actual %0d", e.out_y, got.out_y); errors++;
      end
      if (got.out_z !== e.out_z) begin
        $error("out_z expected %0d actual %0d", e.out_z, got.out_z); errors++;
      end
      if (got.fell_back !== e.fell_back) begin
        $error("fell_back expected %0d actual %0d", e.fell_back, got.fell_back); errors++;
      end
    endfunction
  endclass

  logic clk, rst_n, in_valid, in_stall, out_valid, out_stall, cfg_we;
  in_t in_data;
  out_t out_data;
  logic [0:0] cfg_idx;
  logic [10:0] cfg_data;
  interp_scoreboard sb;

  quaternion_interpolation dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50000000;
    $display("quaternion_interpolation verification failed");
    $finish;
  end

  int stall_mode;
  always @(posedge clk) begin
    if (out_valid && !out_stall) sb.check_result(out_data);
    if (in_valid && !in_stall) sb.note_item(in_data);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 9) < 7);
    endcase
  end

  task automatic write_reg(cfg_reg_e idx, logic [10:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MODE) sb.mode = val[0];
    else sb.limit = val;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic send(in_t q);
    in_valid <= 1'b1;
    in_data <= q;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic pause(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'(int'($urandom_range(0, 32768)) - 16384);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_t rand_item();
    in_t q;
    int r;
    q.first_w = rand_comp(); q.first_x = rand_comp();
    q.first_y = rand_comp(); q.first_z = rand_comp();
    r = $urandom_range(0, 5);
    if (r == 0) begin
      q.second_w = q.first_w; q.second_x = q.first_x;
      q.second_y = q.first_y; q.second_z = q.first_z;
    end else if (r == 1) begin
      q.second_w = -q.first_w; q.second_x = -q.first_x;
      q.second_y = -q.first_y; q.second_z = -q.first_z;
    end else if (r == 2) begin
      q.second_w = 16'(q.first_w + 16'($urandom_range(0, 400)) - 16'sd200);
      q.second_x = 16'(q.first_x + 16'($urandom_range(0, 400)) - 16'sd200);
      q.second_y = q.first_y; q.second_z = q.first_z;
    end else begin
      q.second_w = rand_comp(); q.second_x = rand_comp();
      q.second_y = rand_comp(); q.second_z = rand_comp();
    end
    case ($urandom_range(0, 5))
      0: q.blend = 15'd0;
      1: q.blend = ONE_K;
      2: q.blend = 15'($urandom);
      default: q.blend = 15'($urandom_range(0, 16384));
    endcase
    return q;
  endfunction

  task automatic directed();
    in_t q;
    q = '0;
    send(q);
    q = '{16'sh4000, 0, 0, 0, 16'sh4000, 0, 0, 0, 15'd8192};
    send(q);
    q = '{16'sh4000, 0, 0, 0, -16'sh4000, 0, 0, 0, 15'd8192};
    send(q);
    q = '{16'sh4000, 0, 0, 0, 0, 16'sh4000, 0, 0, 15'd4096};
    send(q);
    q = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
          16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, ONE_K};
    send(q);
    q = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
          16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 15'd0};
    send(q);
    q = '{16'sh2d41, 16'sh2d41, 0, 0, 16'sh4000, 0, 0, 0, 15'h7fff};
    send(q);
    q = '{16'sh4000, 0, 0, 0, 16'sh3fff, 16'sh0100, 0, 0, 15'd20000};
    send(q);
    q = '{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
          16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 15'd1};
    send(q);
    q = '{16'sh4000, 0, 0, 0, 16'sh2000, 16'sh2000, 16'sh2000, 16'sh2000, 15'd16383};
    send(q);
    pause(1);
  endtask

  task automatic random_phase(int n);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && n > 0; i++, n--) send(rand_item());
      if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 12));
    end
    pause(1);
  endtask

  initial begin
    logic [10:0] limits [6];
    limits = '{11'd16, 11'd0, 11'd1024, 11'd2047, 11'd1, 11'd300};
    sb = new();
    sb.mode = 1'b1;
    sb.limit = 11'd16;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = REG_MODE;
    cfg_data = '0;
    stall_mode = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed();
    drain();
    for (int p = 0; p < 12; p++) begin
      write_reg(REG_MODE, 11'(p % 2 == 1 ? 0 : 1));
      write_reg(REG_LIMIT, limits[p % 6]);
      if (p == 1) directed();
      stall_mode = p % 3;
      random_phase(160);
      drain();
    end
    stall_mode = 0;
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("quaternion_interpolation verification clean");
    end else begin
      $display("quaternion_interpolation verification failed");
    end
    $finish;
  end
endmodule
